### rtl/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg - shared types and constants of the circular deque
// sizes, operation and status codes, command and result beats, pointer steps
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH     = 1024;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CAP_W     = $clog2(DEPTH) + 1;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_PUSH,
        CMD_POP,
        CMD_PEEK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic                  at_front;
        logic [WORD_BITS-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]  read_value;
        logic [STATUS_W-1:0]   status;
        logic                  now_empty;
        logic                  now_full;
    } result_t;

    // advance toward the rear, wrapping at the capacity
    function automatic logic [ADDR_W-1:0] step_up(input logic [ADDR_W-1:0] idx,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] last;
        last = cap - CAP_W'(1);
        if ({1'b0, idx} >= last)
            return '0;
        else
            return idx + ADDR_W'(1);
    endfunction

    // move toward the front, wrapping at the capacity
    function automatic logic [ADDR_W-1:0] step_down(input logic [ADDR_W-1:0] idx,
                                                    input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] last;
        last = cap - CAP_W'(1);
        if (idx == '0 || {1'b0, idx} > last)
            return last[ADDR_W-1:0];
        else
            return idx - ADDR_W'(1);
    endfunction

endpackage

### rtl/circular_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_double_ended_queue_unit - double-ended queue in a circular store
// push, pop and peek at either end of a deque of signed words
// ----------------------------------------------------------------------------
// a request is written into the command queue, then executed with the store
//   read, and the result beat is then offered from the output register
// the execution unit runs one command through execute, store read and output
//   register at a time and takes the next command once its result is taken
// reset: pointers and fill count clear, capacity returns to 1024; the entry
//   store is not cleared and is ready at once
module circular_double_ended_queue_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cdq_pkg::OP_W-1:0]        operation,
    input  logic signed [cdq_pkg::WORD_BITS-1:0] push_value,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [cdq_pkg::WORD_BITS-1:0] read_value,
    output logic [cdq_pkg::STATUS_W-1:0]    status,
    output logic                            now_empty,
    output logic                            now_full,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cdq_pkg::PADDR_W-1:0]     paddr,
    input  logic [cdq_pkg::PDATA_W-1:0]     pwdata,
    output logic [cdq_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import cdq_pkg::*;

    logic [CAP_W-1:0]  cap_reg;
    logic [CAP_W-1:0]  cap_eff;
    logic              cap_sel;

    cmd_t              front_cmd;
    logic              front_valid;
    logic              q_full;
    cmd_t              q_cmd;
    logic              q_valid;
    logic              q_take;
    result_t           res;

    // register 0 sits at byte address 0; bit 2 picks the register slot
    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == ADDR_CAPACITY[2]);
    assign prdata  = cap_sel ? PDATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (psel && penable && pwrite && pready && cap_sel)
            cap_reg <= pwdata[CAP_W-1:0];
    end

    // zero acts as one, anything above the store size saturates
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CAP_W'(1);
        else if (cap_reg > CAP_W'(DEPTH))
            cap_eff = CAP_W'(DEPTH);
        else
            cap_eff = cap_reg;
    end

    // decode side
    cdq_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .push_value (push_value),
        .cmd_valid  (front_valid),
        .cmd        (front_cmd),
        .q_full     (q_full)
    );

    // decoupling queue between decode and execution
    cdq_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_cmd   (front_cmd),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd),
        .rd_take  (q_take)
    );

    // execution side with the entry store and the output register
    cdq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_eff),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_take  (q_take),
        .res_valid (out_valid),
        .res       (res),
        .res_stall (out_stall)
    );

    assign read_value = res.read_value;
    assign status     = res.status;
    assign now_empty  = res.now_empty;
    assign now_full   = res.now_full;

endmodule

### rtl/cdq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_front - request decode
// classifies each input beat into a command for the command queue
// ----------------------------------------------------------------------------
module cdq_front (
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cdq_pkg::OP_W-1:0]       operation,
    input  logic [cdq_pkg::WORD_BITS-1:0]  push_value,
    output logic                           cmd_valid,
    output cdq_pkg::cmd_t                  cmd,
    input  logic                           q_full
);
    import cdq_pkg::*;

    assign in_stall  = q_full;
    assign cmd_valid = in_valid;

    always_comb
    begin
        cmd.value    = push_value;
        cmd.kind     = CMD_NOP;
        cmd.at_front = 1'b0;
        unique case (operation)
            OP_PUSH_FRONT:
            begin
                cmd.kind     = CMD_PUSH;
                cmd.at_front = 1'b1;
            end
            OP_PUSH_REAR:
            begin
                cmd.kind = CMD_PUSH;
            end
            OP_POP_FRONT:
            begin
                cmd.kind     = CMD_POP;
                cmd.at_front = 1'b1;
            end
            OP_POP_REAR:
            begin
                cmd.kind = CMD_POP;
            end
            OP_PEEK_FRONT:
            begin
                cmd.kind     = CMD_PEEK;
                cmd.at_front = 1'b1;
            end
            OP_PEEK_REAR:
            begin
                cmd.kind = CMD_PEEK;
            end
            default:
            begin
                // unused codes change nothing
                cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

### rtl/cdq_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cmd_queue - command queue
// short fifo of decoded commands between decode and execution
// ----------------------------------------------------------------------------
module cdq_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    input  cdq_pkg::cmd_t  wr_cmd,
    output logic           full,
    output logic           rd_valid,
    output cdq_pkg::cmd_t  rd_cmd,
    input  logic           rd_take
);
    import cdq_pkg::*;

    cmd_t                slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_wr;
    logic                do_rd;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_take && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_wr && !do_rd)
            count_next = count_reg + QCNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

### rtl/cdq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_back - deque execution
// holds the pointers, fill count and entry store and produces result beats
// ----------------------------------------------------------------------------
module cdq_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [cdq_pkg::CAP_W-1:0]  cap,
    input  logic                       cmd_valid,
    input  cdq_pkg::cmd_t              cmd,
    output logic                       cmd_take,
    output logic                       res_valid,
    output cdq_pkg::result_t           res,
    input  logic                       res_stall
);
    import cdq_pkg::*;

    logic [WORD_BITS-1:0]  store_mem [DEPTH];
    logic [WORD_BITS-1:0]  rd_data_reg;

    logic [ADDR_W-1:0]     head_reg;
    logic [ADDR_W-1:0]     head_next;
    logic [ADDR_W-1:0]     tail_reg;
    logic [ADDR_W-1:0]     tail_next;
    logic [CAP_W-1:0]      fill_reg;
    logic [CAP_W-1:0]      fill_next;

    // execute stage results waiting for the store read
    logic                  pend_reg;
    logic                  pend_use_rd_reg;
    logic                  pend_use_rd_next;
    logic [STATUS_W-1:0]   pend_status_reg;
    logic [STATUS_W-1:0]   pend_status_next;
    logic                  pend_empty_reg;
    logic                  pend_full_reg;

    logic                  res_valid_reg;
    result_t               res_reg;

    logic                  go;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  is_empty;
    logic                  is_full;

    assign go        = cmd_valid && !pend_reg && !res_valid_reg;
    assign cmd_take  = go;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign is_empty  = (fill_reg == '0);
    assign is_full   = (fill_reg >= cap);

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        rd_en            = 1'b0;
        rd_addr          = cmd.at_front ? head_reg : tail_reg;
        pend_use_rd_next = 1'b0;
        pend_status_next = ST_DONE;
        unique case (cmd.kind)
            CMD_PUSH:
            begin
                if (is_full)
                begin
                    pend_status_next = ST_FULL;
                end
                else
                begin
                    wr_en = go;
                    if (is_empty)
                    begin
                        head_next = '0;
                        tail_next = '0;
                        wr_addr   = '0;
                    end
                    else if (cmd.at_front)
                    begin
                        head_next = step_down(head_reg, cap);
                        wr_addr   = head_next;
                    end
                    else
                    begin
                        tail_next = step_up(tail_reg, cap);
                        wr_addr   = tail_next;
                    end
                    fill_next = fill_reg + CAP_W'(1);
                end
            end
            CMD_POP, CMD_PEEK:
            begin
                if (is_empty)
                begin
                    pend_status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en            = go;
                    pend_use_rd_next = 1'b1;
                    if (cmd.kind == CMD_POP)
                    begin
                        if (fill_reg == CAP_W'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else if (cmd.at_front)
                        begin
                            head_next = step_up(head_reg, cap);
                        end
                        else
                        begin
                            tail_next = step_down(tail_reg, cap);
                        end
                        fill_next = fill_reg - CAP_W'(1);
                    end
                end
            end
            default:
            begin
                // no operation
                pend_status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                fill_reg <= fill_next;
            end
            pend_reg <= go;
            if (pend_reg)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            pend_use_rd_reg <= pend_use_rd_next;
            pend_status_reg <= pend_status_next;
            pend_empty_reg  <= (fill_next == '0);
            pend_full_reg   <= (fill_next >= cap);
        end
        if (pend_reg)
        begin
            res_reg.read_value <= pend_use_rd_reg ? rd_data_reg : '1;
            res_reg.status     <= pend_status_reg;
            res_reg.now_empty  <= pend_empty_reg;
            res_reg.now_full   <= pend_full_reg;
        end
    end

    // entry store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= cmd.value;
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

endmodule
